/* rtl/core/u8sd_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types and constants: result status codes, the result record and
// the lead-byte and overlong thresholds of the six-byte legacy form.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

    localparam int unsigned CP_W  = 31;   // code point width
    localparam int unsigned LEN_W = 3;    // sequence length width
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;  // 31 + 3 bits, padded to bytes
    localparam int unsigned OUT_TUSER_W = 2;

    // Result status, carried on the master-side tuser.
    typedef enum logic [1:0] {
        ST_DECODED   = 2'd0,
        ST_INVALID   = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        t_status          status;
        logic [LEN_W-1:0] bad_length;
    } t_result;

    // Lowest lead byte of each sequence length, and the first invalid lead byte.
    localparam logic [7:0] LEAD_2   = 8'hC2;
    localparam logic [7:0] LEAD_3   = 8'hE0;
    localparam logic [7:0] LEAD_4   = 8'hF0;
    localparam logic [7:0] LEAD_5   = 8'hF8;
    localparam logic [7:0] LEAD_6   = 8'hFC;
    localparam logic [7:0] LEAD_BAD = 8'hFF;

    // Smallest second byte that is not overlong after the lowest lead.
    localparam logic [7:0] MIN2_3 = 8'hA0;
    localparam logic [7:0] MIN2_4 = 8'h90;
    localparam logic [7:0] MIN2_5 = 8'h88;
    localparam logic [7:0] MIN2_6 = 8'h84;

    // Continuation bytes are 10xxxxxx.
    localparam logic [1:0] CONT_TAG = 2'b10;

endpackage : u8sd_pkg

`default_nettype wire

/* rtl/core/utf8_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Byte-serial decoder for legacy UTF-8 (up to six bytes) into 31-bit code
// points, with invalid and truncated sequence reporting.
// ----------------------------------------------------------------------------
// Usage:
//   The slave-side stream carries one raw byte per transaction in tdata; tlast
//   marks the final byte of the stream. The master-side stream carries one
//   result per transaction: the code point and the error length in tdata and
//   the status (decoded, invalid, truncated) in tuser.
//   A byte that completes a sequence, an ASCII byte, an invalid lead byte or
//   a byte with tlast set that opens or continues a sequence produces one result; the
//   other bytes of a sequence produce none.
//   Throughput is one byte per cycle while s_axis_tready is high. The result
//   of a byte is presented on the master side from the output register.
//   Decoding is a single pass of shallow logic from the sequence state
//   registers and the incoming byte into the output register.
//   When the receiver stalls, the output register holds its result and a
//   skid register takes one more, so s_axis_tready only drops once both are
//   full; it is driven straight from a register.
//   A synchronous reset (i_rst_n low) abandons any open sequence, empties
//   both output registers and leaves the decoder idle and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Byte stream in
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    input  wire logic [u8sd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
    input  wire logic                                s_axis_tlast,  // end_of_stream
    // Result stream out
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output      logic [u8sd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [30:0] code_point,
                                                                    // [33:31] bad_length,
                                                                    // [39:34] zero
    output      logic [u8sd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser   // [1:0] status
);

    import u8sd_pkg::*;

    // Sequence state
    logic [7:0]       r_lead,   n_lead;
    logic [7:0]       r_second, n_second;
    logic [CP_W-1:0]  r_acc,    n_acc;
    logic [LEN_W-1:0] r_seen,   n_seen;
    logic [LEN_W-1:0] r_need,   n_need;
    logic             r_cbad,   n_cbad;

    // Output register and skid register
    t_result r_out,  r_skid;
    logic    r_out_valid, r_skid_valid;

    logic       s_accept;
    logic       m_pop;
    logic [7:0] byte_in;
    logic       eos;

    t_result    res;
    logic       res_valid;

    logic [LEN_W-1:0] seen_inc;
    logic             tail_bad;
    logic [7:0]       second_now;
    logic             overlong_ok;

    assign byte_in  = s_axis_tdata;
    assign eos      = s_axis_tlast;
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign m_pop    = r_out_valid && m_axis_tready;

    assign seen_inc = r_seen + LEN_W'(1);
    // A continuation byte that is not 10xxxxxx spoils the whole sequence.
    assign tail_bad = r_cbad || (byte_in[7:6] != CONT_TAG);
    // The second byte of the sequence once this byte has been taken.
    assign second_now = (r_seen == LEN_W'(1)) ? byte_in : r_second;

    // Overlong check on the lead and the second byte as it stands after this
    // byte has been taken. Only the lowest lead of each length can be overlong.
    always_comb begin
        case (r_need)
            3'd3:    overlong_ok = (r_lead != LEAD_3) || (second_now >= MIN2_3);
            3'd4:    overlong_ok = (r_lead != LEAD_4) || (second_now >= MIN2_4);
            3'd5:    overlong_ok = (r_lead != LEAD_5) || (second_now >= MIN2_5);
            3'd6:    overlong_ok = (r_lead != LEAD_6) || (second_now >= MIN2_6);
            default: overlong_ok = 1'b1;
        endcase
    end

    // Decode of one byte against the sequence state.
    always_comb begin
        n_lead    = r_lead;
        n_second  = r_second;
        n_acc     = r_acc;
        n_seen    = r_seen;
        n_need    = r_need;
        n_cbad    = r_cbad;
        res_valid = 1'b0;
        res       = '{code_point: '0, status: ST_DECODED, bad_length: '0};

        if (r_seen == '0) begin
            if (byte_in[7] == 1'b0) begin
                // ASCII decodes at once.
                res_valid      = 1'b1;
                res.code_point = CP_W'(byte_in);
            end else if (!(byte_in inside {[LEAD_2:LEAD_BAD - 8'd1]})) begin
                // Stray continuation byte, overlong two-byte lead or 0xFF.
                res_valid      = 1'b1;
                res.status     = ST_INVALID;
                res.bad_length = LEN_W'(1);
            end else begin
                n_lead   = byte_in;
                n_second = '0;
                n_cbad   = 1'b0;
                if (byte_in < LEAD_3) begin
                    n_need = 3'd2;
                    n_acc  = CP_W'(byte_in[4:0]);
                end else if (byte_in < LEAD_4) begin
                    n_need = 3'd3;
                    n_acc  = CP_W'(byte_in[3:0]);
                end else if (byte_in < LEAD_5) begin
                    n_need = 3'd4;
                    n_acc  = CP_W'(byte_in[2:0]);
                end else if (byte_in < LEAD_6) begin
                    n_need = 3'd5;
                    n_acc  = CP_W'(byte_in[1:0]);
                end else begin
                    n_need = 3'd6;
                    n_acc  = CP_W'(byte_in[0]);
                end
                if (eos) begin
                    // Stream ends right after a lead byte.
                    n_seen         = '0;
                    res_valid      = 1'b1;
                    res.status     = ST_TRUNCATED;
                    res.bad_length = LEN_W'(1);
                end else begin
                    n_seen = LEN_W'(1);
                end
            end
        end else begin
            n_second = second_now;
            n_cbad   = tail_bad;
            n_acc    = {r_acc[CP_W-7:0], byte_in[5:0]};
            n_seen   = seen_inc;

            if (seen_inc >= r_need) begin
                // Sequence complete: judge it as a whole.
                n_seen    = '0;
                res_valid = 1'b1;
                if (tail_bad || !overlong_ok) begin
                    res.status     = ST_INVALID;
                    res.bad_length = r_need;
                end else begin
                    res.code_point = n_acc;
                end
            end else if (eos) begin
                n_seen         = '0;
                res_valid      = 1'b1;
                res.status     = ST_TRUNCATED;
                res.bad_length = seen_inc;
            end
        end
    end

    // Sequence state registers. Only the control fields need a reset value;
    // the payload fields are always written before they are read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_need <= '0;
            r_cbad <= 1'b0;
        end else if (s_accept) begin
            r_seen <= n_seen;
            r_need <= n_need;
            r_cbad <= n_cbad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_lead   <= n_lead;
            r_second <= n_second;
            r_acc    <= n_acc;
        end
    end

    // Output register with skid stage. The skid register only fills when a
    // new result arrives while the output register is held by the receiver;
    // while it is full no byte is taken, so it drains first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (m_pop) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (s_accept && res_valid) begin
                if (!r_out_valid || m_pop) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= res;
                    r_skid_valid <= 1'b1;
                end
            end else if (m_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - CP_W - LEN_W)'(0), r_out.bad_length, r_out.code_point};
    assign m_axis_tuser  = r_out.status;

endmodule : utf8_stream_decoder_core

`default_nettype wire

/* rtl/core/u8sd_checker.sv */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Port-level assertions on the decoder core, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tready,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [u8sd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic [u8sd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

    import u8sd_pkg::*;

    // A held result stays put until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // A decoded result carries no error length.
    a_decoded_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_DECODED) |->
            (m_axis_tdata[CP_W+LEN_W-1:CP_W] == '0))
        else $error("decoded result with non-zero error length");

    // An error result has a zero code point and covers one to six bytes.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_DECODED) |->
            (m_axis_tdata[CP_W-1:0] == '0 &&
             m_axis_tdata[CP_W+LEN_W-1:CP_W] != '0 &&
             m_axis_tdata[CP_W+LEN_W-1:CP_W] <= LEN_W'(6) &&
             m_axis_tdata[OUT_TDATA_W-1:CP_W+LEN_W] == '0))
        else $error("malformed error result");

    // Status is never the unused code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == ST_DECODED || m_axis_tuser == ST_INVALID ||
             m_axis_tuser == ST_TRUNCATED))
        else $error("unused status code");

    // The decoder comes out of reset ready to take a byte.
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (s_axis_tready && !m_axis_tvalid))
        else $error("not idle and ready after reset");

endmodule : u8sd_checker

bind utf8_stream_decoder_core u8sd_checker u_u8sd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
